@@ src/ech_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ech_pkg: shared definitions for the event charge histogrammer
// Field widths, register reset values, command and queue entry types.
// ----------------------------------------------------------------------------
package ech_pkg;

	localparam int NUM_BINS_DEF    = 16384;
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int SUM_W       = 28;
	localparam int SPE_W       = 13;
	localparam int COUNT_W     = 32;
	localparam int BIN_IDX_W   = 14;
	localparam int IDX_W       = 16;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 28;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SPE_W-1:0] SPE_RESET        = SPE_W'(16);
	localparam logic [SUM_W-1:0] RANGE_LOW_RESET  = SUM_W'(208000);
	localparam logic [SUM_W-1:0] RANGE_HIGH_RESET = SUM_W'(222000);

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPE        = 2'd0,
		CFG_RANGE_LOW  = 2'd1,
		CFG_RANGE_HIGH = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_kind_t;

	typedef enum logic {
		RES_EVENT = 1'b0,
		RES_READ  = 1'b1
	} res_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WAIT,
		BK_CLEAR
	} bk_state_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [SUM_W-1:0]  sum;
		logic              hit;
		logic [IDX_W-1:0]  idx;
	} op_t;

endpackage
`default_nettype wire

@@ src/ech_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ech_if: channel interfaces of the event charge histogrammer
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ech_req_if import ech_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       command;
	logic [SAMPLE_BITS-1:0] sample_value;
	logic [BIN_IDX_W-1:0]   bin_index;

	modport source (output valid, command, sample_value, bin_index, input ready);
	modport sink (input valid, command, sample_value, bin_index, output ready);
endinterface

interface ech_rsp_if import ech_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [SUM_W-1:0]   event_sum;
	logic               in_range;
	logic [COUNT_W-1:0] bin_count;

	modport source (output valid, result_kind, event_sum, in_range, bin_count,
		input ready);
	modport sink (input valid, result_kind, event_sum, in_range, bin_count,
		output ready);
endinterface

interface ech_cfg_if import ech_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/ech_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ech_fifo: operation queue
// Short queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module ech_fifo import ech_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  op_t  push_op,
	output logic push_ready,
	output logic pop_valid,
	output op_t  pop_op,
	input  logic pop_ready
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule
`default_nettype wire

@@ src/ech_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ech_front: request intake and event integration
// Holds the registers, sums samples into events and classifies operations.
// ----------------------------------------------------------------------------
module ech_front import ech_pkg::*; #(
	parameter int NUM_BINS    = NUM_BINS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ech_cfg_if.sink   cfg,
	ech_req_if.sink   req,
	input  logic      init_busy,
	output logic      push_valid,
	output op_t       push_op,
	input  logic      push_ready
);
	localparam int MS_W  = $clog2(MAX_SAMPLES + 1);
	localparam int CMP_W = (MS_W > SPE_W) ? MS_W : SPE_W;
	localparam logic [CMP_W-1:0] MAX_N   = CMP_W'(MAX_SAMPLES);
	localparam logic [SUM_W-1:0] BINS_SZ = SUM_W'(NUM_BINS);

	logic [SPE_W-1:0]     spe_q;
	logic [SUM_W-1:0]     low_q;
	logic [SUM_W-1:0]     high_q;
	logic [SUM_W-1:0]     rsum_q;
	logic [SPE_W-1:0]     cnt_q;
	logic                 valid_s1;
	op_kind_t             kind_s1;
	logic [SUM_W-1:0]     sum_s1;
	logic [BIN_IDX_W-1:0] idx_s1;

	logic                 accept;
	logic [CMP_W-1:0]     spe_ext;
	logic [CMP_W-1:0]     n_eff;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum_sat;
	logic [SPE_W-1:0]     cnt_inc;
	logic                 ev_done;
	logic                 sample_go;
	logic                 load;
	op_kind_t             kind_d;
	logic                 range_ok;
	logic [SUM_W-1:0]     k_ev;
	logic [SUM_W-1:0]     span;
	logic [SUM_W-1:0]     idx_ext;
	logic                 ev_hit;
	logic                 rd_hit;

	assign cfg.ready = 1'b1;
	assign req.ready = !init_busy && (!valid_s1 || push_ready);
	assign accept    = req.valid && req.ready;

	assign spe_ext   = CMP_W'(spe_q);
	assign n_eff     = (spe_ext > MAX_N) ? MAX_N : spe_ext;
	assign sum_wide  = {1'b0, rsum_q} + (SUM_W + 1)'(req.sample_value);
	assign sum_sat   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
	assign cnt_inc   = cnt_q + SPE_W'(1);
	assign ev_done   = (CMP_W'(cnt_inc) >= n_eff);
	assign sample_go = accept && (cmd_t'(req.command) == CMD_SAMPLE) && (spe_q != '0);

	always_comb begin
		load   = 1'b0;
		kind_d = OP_EVENT;
		if (accept) begin
			unique case (cmd_t'(req.command))
				CMD_SAMPLE: begin
					load   = (spe_q != '0) && ev_done;
					kind_d = OP_EVENT;
				end
				CMD_READ: begin
					load   = 1'b1;
					kind_d = OP_READ;
				end
				CMD_CLEAR: begin
					load   = 1'b1;
					kind_d = OP_CLEAR;
				end
				default: begin
					load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spe_q    <= SPE_RESET;
			low_q    <= RANGE_LOW_RESET;
			high_q   <= RANGE_HIGH_RESET;
			rsum_q   <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_SPE:        spe_q  <= cfg.data[SPE_W-1:0];
					CFG_RANGE_LOW:  low_q  <= cfg.data[SUM_W-1:0];
					CFG_RANGE_HIGH: high_q <= cfg.data[SUM_W-1:0];
					default: begin
					end
				endcase
			end
			if (sample_go) begin
				if (ev_done) begin
					rsum_q <= '0;
					cnt_q  <= '0;
				end else begin
					rsum_q <= sum_sat;
					cnt_q  <= cnt_inc;
				end
			end
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1 <= kind_d;
			sum_s1  <= sum_sat;
			idx_s1  <= req.bin_index;
		end
	end

	// The store is kept in reversed order, so an event lands in bin high-1-sum.
	assign range_ok = (low_q < high_q);
	assign k_ev     = high_q - SUM_W'(1) - sum_s1;
	assign span     = high_q - low_q;
	assign idx_ext  = SUM_W'(idx_s1);
	assign ev_hit   = range_ok && (sum_s1 >= low_q) && (sum_s1 < high_q) && (k_ev < BINS_SZ);
	assign rd_hit   = range_ok && (idx_ext < BINS_SZ) && (idx_ext < span);

	assign push_valid   = valid_s1;
	assign push_op.kind = kind_s1;
	assign push_op.sum  = sum_s1;
	assign push_op.hit  = (kind_s1 == OP_EVENT) ? ev_hit : rd_hit;
	assign push_op.idx  = (kind_s1 == OP_EVENT) ? IDX_W'(k_ev) : IDX_W'(idx_s1);

endmodule
`default_nettype wire

@@ src/ech_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ech_back: histogram store and result output
// Executes queued operations on the bin memory and drives the response.
// ----------------------------------------------------------------------------
module ech_back import ech_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  op_t        pop_op,
	output logic       pop_ready,
	output logic       init_busy,
	ech_rsp_if.source  rsp
);
	localparam int ADDR_W = $clog2(NUM_BINS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

	bk_state_t          state_q;
	bk_state_t          state_d;
	op_t                cur_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               init_q;
	logic [COUNT_W-1:0] mem [NUM_BINS];
	logic [COUNT_W-1:0] rd_data_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [COUNT_W-1:0] wr_data;

	logic               out_valid_q;
	res_kind_t          out_kind_q;
	logic [SUM_W-1:0]   out_sum_q;
	logic               out_in_range_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_free;
	logic               out_load;
	res_kind_t          out_kind_d;
	logic [SUM_W-1:0]   out_sum_d;
	logic               out_in_range_d;
	logic [COUNT_W-1:0] out_count_d;

	assign out_free  = !out_valid_q || rsp.ready;
	assign init_busy = init_q;

	always_comb begin
		state_d        = state_q;
		pop_ready      = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = pop_op.idx[ADDR_W-1:0];
		wr_en          = 1'b0;
		wr_addr        = clr_addr_q;
		wr_data        = '0;
		out_load       = 1'b0;
		out_kind_d     = RES_EVENT;
		out_sum_d      = pop_op.sum;
		out_in_range_d = 1'b0;
		out_count_d    = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					unique case (pop_op.kind)
						OP_EVENT: begin
							if (out_free) begin
								pop_ready      = 1'b1;
								out_load       = 1'b1;
								out_kind_d     = RES_EVENT;
								out_in_range_d = pop_op.hit;
								if (pop_op.hit) begin
									rd_en   = 1'b1;
									state_d = BK_WAIT;
								end
							end
						end
						OP_READ: begin
							if (out_free) begin
								pop_ready = 1'b1;
								if (pop_op.hit) begin
									rd_en   = 1'b1;
									state_d = BK_WAIT;
								end else begin
									out_load   = 1'b1;
									out_kind_d = RES_READ;
									out_sum_d  = '0;
								end
							end
						end
						OP_CLEAR: begin
							pop_ready = 1'b1;
							state_d   = BK_CLEAR;
						end
						default: begin
							pop_ready = 1'b1;
						end
					endcase
				end
			end
			BK_WAIT: begin
				state_d = BK_IDLE;
				if (cur_q.kind == OP_READ) begin
					out_load    = 1'b1;
					out_kind_d  = RES_READ;
					out_sum_d   = '0;
					out_count_d = rd_data_q;
				end else begin
					wr_en   = 1'b1;
					wr_addr = cur_q.idx[ADDR_W-1:0];
					wr_data = (&rd_data_q) ? rd_data_q : rd_data_q + COUNT_W'(1);
				end
			end
			BK_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				if (clr_addr_q == LAST_ADDR) begin
					clr_addr_q <= '0;
					init_q     <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready) begin
			cur_q <= pop_op;
		end
		if (out_load) begin
			out_kind_q     <= out_kind_d;
			out_sum_q      <= out_sum_d;
			out_in_range_q <= out_in_range_d;
			out_count_q    <= out_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.event_sum   = out_sum_q;
	assign rsp.in_range    = out_in_range_q;
	assign rsp.bin_count   = out_count_q;

`ifndef SYNTHESIS
	a_wait_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_WAIT |=> state_q != BK_WAIT)
		else $error("Memory wait state lasted more than one cycle.");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_WAIT && cur_q.kind == OP_READ) |-> !out_valid_q)
		else $error("Read data arrived while the output register was occupied.");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR && clr_addr_q == LAST_ADDR) |=> state_q == BK_IDLE)
		else $error("Clear sweep did not end after the last bin.");

	a_init_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> state_q == BK_CLEAR)
		else $error("Initial clear flag set outside the clear sweep.");

	a_bin_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_WAIT |-> 32'(cur_q.idx) < NUM_BINS)
		else $error("Memory access beyond the last bin.");
`endif

endmodule
`default_nettype wire

@@ src/event_charge_histogrammer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// event_charge_histogrammer: pulse-height multichannel analyzer
// Integrates detector samples into event sums and histograms them.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  cfg      in         register index and write data
//  req      in         command, sample_value, bin_index
//  rsp      out        result_kind, event_sum, in_range, bin_count
//
//  Samples are taken one per cycle when req.ready is high; the sum and count
//  update in the cycle a sample is accepted, and a finished event is registered
//  before the queue. An uncounted event needs only BK_IDLE; a counted event or
//  in-range bin read also passes BK_WAIT for the registered read of the single
//  bin memory. A clear command occupies the store while it zeroes every bin,
//  one bin a cycle. After reset the store is swept clear and no request is
//  taken. A stalled rsp backs up the queue of depth four, then the requests.
// ----------------------------------------------------------------------------
module event_charge_histogrammer import ech_pkg::*; #(
	parameter int NUM_BINS    = NUM_BINS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ech_cfg_if.sink    cfg,
	ech_req_if.sink    req,
	ech_rsp_if.source  rsp
);
	logic push_valid;
	op_t  push_op;
	logic push_ready;
	logic pop_valid;
	op_t  pop_op;
	logic pop_ready;
	logic init_busy;

	ech_front #(
		.NUM_BINS    (NUM_BINS),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.init_busy  (init_busy),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	ech_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	ech_back #(
		.NUM_BINS (NUM_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_op    (pop_op),
		.pop_ready (pop_ready),
		.init_busy (init_busy),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
